@@ hdl/mlt_pkg.sv @@
// Shared types and status codes for the MAC address learning table.
// Used by mlt_cell and mac_learning_table; depends on nothing else.
`default_nettype none

package mlt_pkg;

  typedef logic [2:0] status_t;

  localparam status_t ST_NONE    = 3'd0;
  localparam status_t ST_MULTI   = 3'd1;
  localparam status_t ST_BCAST   = 3'd2;
  localparam status_t ST_LEARNED = 3'd3;
  localparam status_t ST_MOVED   = 3'd4;
  localparam status_t ST_BADPORT = 3'd5;
  localparam status_t ST_FULL    = 3'd6;

  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;
  localparam int          GROUP_BIT = 40;

  // Lookup request as it travels along the row of cells.
  typedef struct packed {
    logic        vld;
    logic [47:0] mac;
    logic [15:0] port;
    logic [11:0] vlan;
    logic        found;
    logic        have_free;
    status_t     status;
    logic [15:0] moves;
    logic        added;
    logic        overflow;
  } tok_t;

  // Learn command broadcast from the end of the row to every cell.
  typedef struct packed {
    logic        vld;
    logic [47:0] mac;
    logic [15:0] port;
    logic [11:0] vlan;
  } lrn_t;

endpackage

`default_nettype wire

@@ hdl/mlt_cell.sv @@
// One table entry with its VLAN set, plus one stage of the lookup chain.
// Depends on mlt_pkg for the request and learn command types.
`default_nettype none

module mlt_cell #(
  parameter int VLANS_PER_ENTRY = 4
) (
  input  wire            clk,
  input  wire            rst_n,
  input  mlt_pkg::tok_t  tok_i,
  output mlt_pkg::tok_t  tok_o,
  input  mlt_pkg::lrn_t  lrn_i
);

  localparam int VW = VLANS_PER_ENTRY;

  logic          valid_r, valid_nxt;
  logic [47:0]   mac_r, mac_nxt;
  logic [15:0]   port_r, port_nxt;
  logic [15:0]   moves_r, moves_nxt;
  logic [VW-1:0] vused_r, vused_nxt;
  logic [11:0]   vid_r [VW];
  logic [11:0]   vid_nxt [VW];
  logic          cand_r, cand_nxt;
  mlt_pkg::tok_t tok_r, tok_nxt;

  logic          hit;
  logic          free_here;
  logic          port_diff;
  logic [15:0]   moves_new;
  logic [VW-1:0] vused_base;
  logic [VW-1:0] empty_vec;
  logic [VW-1:0] pick;
  logic          present;
  logic          need_add;
  logic          added;
  logic          overflow;

  always_comb begin
    hit       = tok_i.vld && valid_r && !tok_i.found && (mac_r == tok_i.mac);
    free_here = tok_i.vld && !valid_r && !tok_i.have_free;
    port_diff = port_r != tok_i.port;
    if (!port_diff) begin
      moves_new = moves_r;
    end else if (moves_r == 16'hFFFF) begin
      moves_new = moves_r;
    end else begin
      moves_new = moves_r + 16'd1;
    end
    // A move to a new port forgets the VLANs seen so far.
    vused_base = port_diff ? '0 : vused_r;
    present = 1'b0;
    for (int k = 0; k < VW; k++) begin
      if (vused_base[k] && (vid_r[k] == tok_i.vlan)) begin
        present = 1'b1;
      end
    end
    // Lowest unused position of the set, as a one-hot vector.
    empty_vec = ~vused_base;
    pick      = empty_vec & (~empty_vec + VW'(1));
    need_add  = (tok_i.vlan != 12'd0) && !present;
    added     = need_add && (|empty_vec);
    overflow  = need_add && !(|empty_vec);
  end

  always_comb begin
    valid_nxt = valid_r;
    mac_nxt   = mac_r;
    port_nxt  = port_r;
    moves_nxt = moves_r;
    vused_nxt = vused_r;
    for (int k = 0; k < VW; k++) begin
      vid_nxt[k] = vid_r[k];
    end
    cand_nxt = tok_i.vld ? free_here : cand_r;
    tok_nxt  = tok_i;

    if (hit) begin
      port_nxt  = tok_i.port;
      moves_nxt = moves_new;
      vused_nxt = added ? (vused_base | pick) : vused_base;
      for (int k = 0; k < VW; k++) begin
        if (added && pick[k]) begin
          vid_nxt[k] = tok_i.vlan;
        end
      end
      tok_nxt.found    = 1'b1;
      tok_nxt.status   = port_diff ? mlt_pkg::ST_MOVED : mlt_pkg::ST_NONE;
      tok_nxt.moves    = moves_new;
      tok_nxt.added    = added;
      tok_nxt.overflow = overflow;
    end
    tok_nxt.have_free = tok_i.have_free || free_here;

    // The lowest free cell of the last request takes the new address.
    if (lrn_i.vld && cand_r) begin
      valid_nxt  = 1'b1;
      mac_nxt    = lrn_i.mac;
      port_nxt   = lrn_i.port;
      moves_nxt  = 16'd0;
      vused_nxt  = (lrn_i.vlan != 12'd0) ? VW'(1) : '0;
      vid_nxt[0] = lrn_i.vlan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      vused_r   <= '0;
      cand_r    <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      vused_r <= vused_nxt;
      cand_r  <= cand_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mac_r   <= mac_nxt;
    port_r  <= port_nxt;
    moves_r <= moves_nxt;
    for (int k = 0; k < VW; k++) begin
      vid_r[k] <= vid_nxt[k];
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

@@ hdl/mac_learning_table.sv @@
// Top level of the MAC address learning table: request filter, cell row, result.
// Depends on mlt_pkg and mlt_cell.
//
//   channel | ports                                   | handshake
//   request | in_ingress_port, in_vlan_id, in_source_mac | start & !busy
//   result  | out_status, out_move_count, out_vlan_*   | out_valid, one cycle
//
// A request with port 0, a group or the broadcast source gives its result in the
// cycle after acceptance and leaves busy low. Any other request walks the row of
// TABLE_DEPTH cells, one cell a cycle, so busy stays high while it is in the row,
// and the next request can be taken only once it has left the last cell.
// The result appears in the cycle in which busy falls; the receiver cannot stall.
// Reset clears every entry's valid and VLAN used bits at once, with no sweep.
`default_nettype none

module mac_learning_table #(
  parameter int TABLE_DEPTH     = 64,
  parameter int VLANS_PER_ENTRY = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [15:0] in_ingress_port,
  input  wire  [11:0] in_vlan_id,
  input  wire  [47:0] in_source_mac,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_move_count,
  output logic        out_vlan_added,
  output logic        out_vlan_overflow
);

  logic                  accept;
  logic                  filtered;
  mlt_pkg::status_t      filt_status;
  logic                  busy_r, busy_nxt;
  mlt_pkg::tok_t         req_r, req_nxt;
  mlt_pkg::tok_t         tok_w [TABLE_DEPTH+1];
  mlt_pkg::tok_t         tail;
  mlt_pkg::lrn_t         lrn;
  logic [TABLE_DEPTH:0]  tok_vld_w;

  logic                  out_valid_r, out_valid_nxt;
  mlt_pkg::status_t      out_status_r, out_status_nxt;
  logic [15:0]           out_moves_r, out_moves_nxt;
  logic                  out_added_r, out_added_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  assign accept = start && !busy_r;

  always_comb begin
    filtered    = 1'b1;
    filt_status = mlt_pkg::ST_NONE;
    if (in_ingress_port == 16'd0) begin
      filt_status = mlt_pkg::ST_BADPORT;
    end else if (in_source_mac == mlt_pkg::MAC_BCAST) begin
      filt_status = mlt_pkg::ST_BCAST;
    end else if (in_source_mac[mlt_pkg::GROUP_BIT]) begin
      filt_status = mlt_pkg::ST_MULTI;
    end else begin
      filtered = 1'b0;
    end
  end

  always_comb begin
    req_nxt           = req_r;
    req_nxt.vld       = accept && !filtered;
    req_nxt.mac       = in_source_mac;
    req_nxt.port      = in_ingress_port;
    req_nxt.vlan      = in_vlan_id;
    req_nxt.found     = 1'b0;
    req_nxt.have_free = 1'b0;
    req_nxt.status    = mlt_pkg::ST_NONE;
    req_nxt.moves     = 16'd0;
    req_nxt.added     = 1'b0;
    req_nxt.overflow  = 1'b0;
  end

  assign tok_w[0] = req_r;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      mlt_cell #(
        .VLANS_PER_ENTRY(VLANS_PER_ENTRY)
      ) u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .tok_i(tok_w[gi]),
        .tok_o(tok_w[gi+1]),
        .lrn_i(lrn)
      );
    end
    for (gi = 0; gi <= TABLE_DEPTH; gi++) begin : g_vld
      assign tok_vld_w[gi] = tok_w[gi].vld;
    end
  endgenerate

  assign tail = tok_w[TABLE_DEPTH];

  always_comb begin
    lrn.vld  = tail.vld && !tail.found && tail.have_free;
    lrn.mac  = tail.mac;
    lrn.port = tail.port;
    lrn.vlan = tail.vlan;
  end

  always_comb begin
    busy_nxt = busy_r;
    if (accept && !filtered) begin
      busy_nxt = 1'b1;
    end else if (tail.vld) begin
      busy_nxt = 1'b0;
    end

    out_valid_nxt  = 1'b0;
    out_status_nxt = mlt_pkg::ST_NONE;
    out_moves_nxt  = 16'd0;
    out_added_nxt  = 1'b0;
    out_ovf_nxt    = 1'b0;
    if (accept && filtered) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = filt_status;
    end else if (tail.vld) begin
      out_valid_nxt = 1'b1;
      if (tail.found) begin
        out_status_nxt = tail.status;
        out_moves_nxt  = tail.moves;
        out_added_nxt  = tail.added;
        out_ovf_nxt    = tail.overflow;
      end else if (tail.have_free) begin
        out_status_nxt = mlt_pkg::ST_LEARNED;
        out_added_nxt  = tail.vlan != 12'd0;
      end else begin
        out_status_nxt = mlt_pkg::ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      req_r.vld   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      req_r       <= req_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_moves_r  <= out_moves_nxt;
    out_added_r  <= out_added_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign busy              = busy_r;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_move_count    = out_moves_r;
  assign out_vlan_added    = out_added_r;
  assign out_vlan_overflow = out_ovf_r;

  // At most one request is ever inside the row.
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld_w))
    else $error("more than one request in the cell row");

  a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> busy_r)
    else $error("request left the row while not busy");

  a_enter_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !filtered) |=> busy_r && req_r.vld)
    else $error("table request accepted without entering the row");

  a_learn_result: assert property (@(posedge clk) disable iff (!rst_n)
    lrn.vld |=> out_valid_r && (out_status_r == mlt_pkg::ST_LEARNED))
    else $error("learn command without a learned result");

  a_no_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == mlt_pkg::ST_MULTI ||
                    out_status_r == mlt_pkg::ST_BCAST ||
                    out_status_r == mlt_pkg::ST_BADPORT ||
                    out_status_r == mlt_pkg::ST_FULL)
    |-> (out_moves_r == 16'd0) && !out_added_r && !out_ovf_r)
    else $error("result without an entry carries nonzero fields");

endmodule

`default_nettype wire

@@ bench/tb_mac_learning_table.sv @@
// Self-checking bench for mac_learning_table: directed and random learning requests.
// Holds its own model of the address table and VLAN sets; depends on mlt_pkg and the RTL.
`timescale 1ns / 100ps

module tb_mac_learning_table;

  localparam int TABLE_DEPTH     = 64;
  localparam int VLANS_PER_ENTRY = 4;
  localparam int POOL_SIZE       = 72;
  localparam int RANDOM_ITEMS    = 1830;
  localparam int CYCLE_LIMIT     = 1_000_000;

  typedef struct packed {
    mlt_pkg::status_t status;
    logic [15:0]      moves;
    logic             added;
    logic             overflow;
  } learn_outcome_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_ingress_port;
  logic [11:0] in_vlan_id;
  logic [47:0] in_source_mac;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [15:0] out_move_count;
  logic        out_vlan_added;
  logic        out_vlan_overflow;

  // Model of the table: entries and their VLAN sets.
  bit          tbl_valid [TABLE_DEPTH];
  logic [47:0] tbl_mac   [TABLE_DEPTH];
  logic [15:0] tbl_port  [TABLE_DEPTH];
  logic [15:0] tbl_moves [TABLE_DEPTH];
  bit          vset_used [TABLE_DEPTH][VLANS_PER_ENTRY];
  logic [11:0] vset_id   [TABLE_DEPTH][VLANS_PER_ENTRY];

  learn_outcome_t outcomes_due[$];

  int fail_count;
  int request_count;
  int result_count;
  int cycle_count;
  int status_seen [8];
  int vlan_adds;
  int vlan_overflows;

  mac_learning_table #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .VLANS_PER_ENTRY (VLANS_PER_ENTRY)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_ingress_port   (in_ingress_port),
    .in_vlan_id        (in_vlan_id),
    .in_source_mac     (in_source_mac),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_move_count    (out_move_count),
    .out_vlan_added    (out_vlan_added),
    .out_vlan_overflow (out_vlan_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the learning status of one frame and updates the table model.
  function automatic learn_outcome_t learn_source(input logic [15:0] port,
                                                  input logic [11:0] vlan,
                                                  input logic [47:0] mac);
    learn_outcome_t res;
    int  slot;
    int  free_slot;
    int  empty_k;
    bit  found;
    bit  have_free;
    bit  present;
    bit  have_empty;
    res       = '0;
    slot      = 0;
    free_slot = 0;
    empty_k   = 0;
    found     = 1'b0;
    have_free = 1'b0;
    if (port == 16'd0) begin
      res.status = mlt_pkg::ST_BADPORT;
      return res;
    end
    // The all-ones address also has the group bit, so it is tested first.
    if (mac == mlt_pkg::MAC_BCAST) begin
      res.status = mlt_pkg::ST_BCAST;
      return res;
    end
    if (mac[mlt_pkg::GROUP_BIT]) begin
      res.status = mlt_pkg::ST_MULTI;
      return res;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_valid[i]) begin
        if (!found && tbl_mac[i] == mac) begin
          found = 1'b1;
          slot  = i;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_slot = i;
      end
    end
    res.status = mlt_pkg::ST_NONE;
    if (!found) begin
      if (!have_free) begin
        res.status = mlt_pkg::ST_FULL;
        return res;
      end
      slot            = free_slot;
      tbl_valid[slot] = 1'b1;
      tbl_mac[slot]   = mac;
      tbl_port[slot]  = port;
      tbl_moves[slot] = 16'd0;
      for (int k = 0; k < VLANS_PER_ENTRY; k++) vset_used[slot][k] = 1'b0;
      res.status = mlt_pkg::ST_LEARNED;
    end else if (tbl_port[slot] != port) begin
      tbl_port[slot] = port;
      if (tbl_moves[slot] != 16'hFFFF) tbl_moves[slot] = tbl_moves[slot] + 16'd1;
      for (int k = 0; k < VLANS_PER_ENTRY; k++) vset_used[slot][k] = 1'b0;
      res.status = mlt_pkg::ST_MOVED;
    end
    if (vlan != 12'd0) begin
      present    = 1'b0;
      have_empty = 1'b0;
      for (int k = 0; k < VLANS_PER_ENTRY; k++) begin
        if (vset_used[slot][k]) begin
          if (vset_id[slot][k] == vlan) present = 1'b1;
        end else if (!have_empty) begin
          have_empty = 1'b1;
          empty_k    = k;
        end
      end
      if (!present) begin
        if (have_empty) begin
          vset_used[slot][empty_k] = 1'b1;
          vset_id[slot][empty_k]   = vlan;
          res.added = 1'b1;
        end else begin
          res.overflow = 1'b1;
        end
      end
    end
    res.moves = tbl_moves[slot];
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with
  // start still high, so that a following request can go straight out.
  task automatic send_request(input logic [15:0] port, input logic [11:0] vlan,
                              input logic [47:0] mac);
    start           <= 1'b1;
    in_ingress_port <= port;
    in_vlan_id      <= vlan;
    in_source_mac   <= mac;
    do @(posedge clk); while (busy !== 1'b0);
    outcomes_due.push_back(learn_source(port, vlan, mac));
    request_count++;
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_all_returned();
    start <= 1'b0;
    while (outcomes_due.size() != 0) @(negedge clk);
  endtask

  task automatic test_filtered_sources();
    send_request(16'h0000, 12'h000, 48'h0000_0000_0000);
    send_request(16'h0000, 12'hFFF, mlt_pkg::MAC_BCAST);
    send_request(16'hFFFF, 12'hFFF, mlt_pkg::MAC_BCAST);
    send_request(16'h0001, 12'h001, 48'h0100_5E00_0001);
    send_request(16'h8000, 12'h000, 48'hFFFF_FFFF_FFFE);
    wait_all_returned();
  endtask

  task automatic test_learn_and_vlans();
    send_request(16'hFFFF, 12'h000, 48'h0000_0000_0000);
    send_request(16'hFFFF, 12'hFFF, 48'h0000_0000_0000);
    send_request(16'hFFFF, 12'h001, 48'h0000_0000_0000);
    send_request(16'hFFFF, 12'h002, 48'h0000_0000_0000);
    send_request(16'hFFFF, 12'h003, 48'h0000_0000_0000);
    // The set now holds four VLANs, so a fifth one overflows.
    send_request(16'hFFFF, 12'h005, 48'h0000_0000_0000);
    send_request(16'hFFFF, 12'h002, 48'h0000_0000_0000);
    pause_sender(3);
    send_request(16'h0001, 12'h800, 48'hFEFF_FFFF_FFFF);
    wait_all_returned();
  endtask

  task automatic test_port_moves();
    send_request(16'h0001, 12'h007, 48'h0000_0000_0000);
    send_request(16'h0001, 12'h000, 48'h0000_0000_0000);
    send_request(16'hFFFF, 12'h000, 48'h0000_0000_0000);
    send_request(16'h0002, 12'h800, 48'hFEFF_FFFF_FFFF);
    wait_all_returned();
  endtask

  // Mostly unicast sources from a pool a little larger than the table, so that
  // hits, moves and VLAN set growth dominate until the table fills.
  task automatic test_random_traffic();
    logic [47:0] pool [POOL_SIZE];
    logic [63:0] r64;
    logic [15:0] port;
    logic [11:0] vlan;
    logic [47:0] mac;
    int          burst;
    int          gap;
    int          r;
    for (int p = 0; p < POOL_SIZE; p++) begin
      r64                         = {$urandom, $urandom};
      pool[p]                     = r64[47:0];
      pool[p][mlt_pkg::GROUP_BIT] = 1'b0;
    end
    burst = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n > 0 && n % 400 == 0) wait_all_returned();
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        r     = $urandom_range(0, 99);
        if (r < 20)      gap = 0;
        else if (r < 70) gap = $urandom_range(1, 4);
        else if (r < 92) gap = $urandom_range(5, 30);
        else             gap = $urandom_range(31, 90);
        if (gap > 0) pause_sender(gap);
      end
      burst--;

      r = $urandom_range(0, 99);
      if (r < 3)       port = 16'd0;
      else if (r < 13) port = 16'($urandom_range(0, 65535));
      else if (r < 28) port = 16'd2;
      else             port = 16'd1;

      r = $urandom_range(0, 99);
      if (r < 12)      vlan = 12'd0;
      else if (r < 18) vlan = 12'($urandom_range(0, 4095));
      else             vlan = 12'($urandom_range(1, 6));

      r = $urandom_range(0, 99);
      if (r < 6) begin
        r64 = {$urandom, $urandom};
        mac = r64[47:0];
      end else if (r < 8) begin
        mac = mlt_pkg::MAC_BCAST;
      end else begin
        mac = pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      send_request(port, vlan, mac);
    end
  endtask

  // Results are sampled at the rising edge that accepts them.
  always @(posedge clk) begin
    learn_outcome_t want;
    if (rst_n) begin
      if ($isunknown(out_valid)) begin
        if (fail_count < 10) $display("out_valid unknown at cycle %0d", cycle_count);
        fail_count++;
      end else if (out_valid) begin
        status_seen[out_status]++;
        if (out_vlan_added === 1'b1) vlan_adds++;
        if (out_vlan_overflow === 1'b1) vlan_overflows++;
        if (outcomes_due.size() == 0) begin
          if (fail_count < 10)
            $display("result at cycle %0d with no request outstanding", cycle_count);
          fail_count++;
        end else begin
          want = outcomes_due.pop_front();
          if (out_status !== want.status || out_move_count !== want.moves ||
              out_vlan_added !== want.added || out_vlan_overflow !== want.overflow) begin
            if (fail_count < 10)
              $display("result %0d exp/act: st %0d/%0d mv %0d/%0d add %0b/%0b ovf %0b/%0b",
                       result_count, want.status, out_status, want.moves, out_move_count,
                       want.added, out_vlan_added, want.overflow, out_vlan_overflow);
            fail_count++;
          end
        end
        result_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int learned;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_ingress_port = 16'd0;
    in_vlan_id      = 12'd0;
    in_source_mac   = 48'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_filtered_sources();
    test_learn_and_vlans();
    test_port_moves();
    test_random_traffic();

    wait_all_returned();
    repeat (TABLE_DEPTH + 4) @(negedge clk);
    if (outcomes_due.size() != 0) begin
      $display("%0d results never arrived", outcomes_due.size());
      fail_count++;
    end

    learned = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) if (tbl_valid[i]) learned++;
    $display("%0d requests, %0d results, %0d failures; %0d of %0d entries in use",
             request_count, result_count, fail_count, learned, TABLE_DEPTH);
    $display("none %0d mcast %0d bcast %0d learned %0d moved %0d badport %0d full %0d; %s %0d/%0d",
             status_seen[mlt_pkg::ST_NONE], status_seen[mlt_pkg::ST_MULTI],
             status_seen[mlt_pkg::ST_BCAST], status_seen[mlt_pkg::ST_LEARNED],
             status_seen[mlt_pkg::ST_MOVED], status_seen[mlt_pkg::ST_BADPORT],
             status_seen[mlt_pkg::ST_FULL], "VLAN adds/overflows", vlan_adds,
             vlan_overflows);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
